### rtl/core/lnrb_pkg.sv
// shared types and constants for the last-n-lines ring buffer
package lnrb_pkg;

    // operation codes carried by the func field
    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_EOI  = 2'd1,
        FUNC_PULL = 2'd2
    } t_func;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;

    localparam logic [BYTE_W-1:0]  NEWLINE          = 8'h0A;
    localparam logic [COUNT_W-1:0] LINES_WANTED_RST = 8'd5;

endpackage

### rtl/core/lnrb_ram.sv
// generic single-write, single-read ram with registered read data
module lnrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/last_n_lines_ring_buffer.sv
// top level of the last-n-lines ring buffer: line capture and tail replay
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall       | i_func, i_data_byte
//  out     | from block| o_out_valid / i_out_stall     | o_out_byte, o_last_byte,
//          |           |                               | o_nothing_left, o_lines_shown
//  cfg     | to block  | i_cfg_valid / o_cfg_ready     | i_cfg_data (lines wanted)
//
// one item per cycle while the output is not stalled; an accepted beat passes the middle stage and
// then the result stage, the middle stage waiting on the registered read of the line store
// pointer and count state is updated at accept time; lengths come from a slot-length ram
// read every cycle at the next replay slot, with a bypass for a write in the same cycle
// synchronous active-low reset clears the pointers; the memories are not cleared
// a stalled output holds the result stage and back-pressures the input while the middle stage holds a beat
module last_n_lines_ring_buffer
    import lnrb_pkg::*;
#(
    parameter int unsigned LINE_SLOTS = 128,
    parameter int unsigned LINE_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [BYTE_W-1:0]  i_data_byte,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last_byte,
    output logic               o_nothing_left,
    output logic [COUNT_W-1:0] o_lines_shown,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int unsigned SLOT_W  = $clog2(LINE_SLOTS);
    localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
    localparam int unsigned HELD_W  = $clog2(LINE_SLOTS + 1);
    localparam int unsigned ADDR_W  = SLOT_W + OFF_W;
    localparam int unsigned STORE_D = LINE_SLOTS << OFF_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(LINE_SLOTS - 1);
    localparam logic [HELD_W-1:0] HELD_FULL  = HELD_W'(LINE_SLOTS);
    localparam logic [OFF_W:0]    LINE_LIMIT = (OFF_W + 1)'(LINE_BYTES - 1);

    // control and pointer state
    logic [COUNT_W-1:0] r_lines_wanted;
    logic [SLOT_W-1:0]  r_write_slot,     n_write_slot;
    logic [OFF_W-1:0]   r_partial_length, n_partial_length;
    logic [HELD_W-1:0]  r_lines_held,     n_lines_held;
    logic [SLOT_W-1:0]  r_replay_slot,    n_replay_slot;
    logic [OFF_W-1:0]   r_replay_offset,  n_replay_offset;
    logic [HELD_W-1:0]  r_lines_remaining, n_lines_remaining;
    logic               r_in_replay,      n_in_replay;

    // middle stage, waiting on the store read
    logic               r_s1_valid,    n_s1_valid;
    logic               r_s1_has_byte, n_s1_has_byte;
    logic               r_s1_last,     n_s1_last;
    logic               r_s1_none,     n_s1_none;
    logic [COUNT_W-1:0] r_s1_shown,    n_s1_shown;

    // result stage
    logic               r_o_valid;
    logic [BYTE_W-1:0]  r_o_out_byte;
    logic               r_o_last;
    logic               r_o_none;
    logic [COUNT_W-1:0] r_o_shown;

    // slot-length bypass for a write that lands on the address being read
    logic               r_len_hit;
    logic [OFF_W-1:0]   r_len_byp;

    // memory ports
    logic               store_we;
    logic [ADDR_W-1:0]  store_waddr;
    logic               store_re;
    logic [ADDR_W-1:0]  store_raddr;
    logic [BYTE_W-1:0]  store_rdata;
    logic               len_we;
    logic [SLOT_W-1:0]  len_waddr;
    logic [OFF_W-1:0]   len_wdata;
    logic [OFF_W-1:0]   len_rdata;
    logic [OFF_W-1:0]   cur_len;

    // handshake
    logic               s1_adv;
    logic               in_accept;
    t_func              func;

    // helper values
    logic [SLOT_W-1:0]  ws_inc;
    logic [SLOT_W-1:0]  rs_inc;
    logic [HELD_W-1:0]  held_inc;
    logic               eoi_close;
    logic [SLOT_W-1:0]  eoi_ws;
    logic [HELD_W-1:0]  eoi_held;
    logic [HELD_W-1:0]  want_cap;
    logic [HELD_W-1:0]  eoi_n;
    logic [HELD_W:0]    start_sum;
    logic [HELD_W:0]    start_slot;
    logic [SLOT_W-1:0]  push_ws;
    logic [SLOT_W-1:0]  push_ws_inc;
    logic [OFF_W-1:0]   push_pl;
    logic [HELD_W-1:0]  push_held_inc;
    logic [OFF_W:0]     push_pl_new;
    logic               push_close;
    logic [OFF_W:0]     off_inc;
    logic               pull_adv;
    logic               pull_empty;
    logic [HELD_W-1:0]  rem_dec;

    // handshake and flow control
    assign s1_adv      = !r_o_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign func        = t_func'(i_func);
    assign o_cfg_ready = 1'b1;

    // length of the slot under replay, with write bypass
    assign cur_len = r_len_hit ? r_len_byp : len_rdata;

    // wrap-around increments
    assign ws_inc   = (r_write_slot == SLOT_LAST) ? '0 : r_write_slot + 1'b1;
    assign rs_inc   = (r_replay_slot == SLOT_LAST) ? '0 : r_replay_slot + 1'b1;
    assign held_inc = (r_lines_held == HELD_FULL) ? r_lines_held : r_lines_held + 1'b1;
    assign rem_dec  = r_lines_remaining - 1'b1;

    // end of input: close partial line, clamp count, find first replay slot
    assign eoi_close = (r_partial_length != '0);
    assign eoi_ws    = eoi_close ? ws_inc : r_write_slot;
    assign eoi_held  = eoi_close ? held_inc : r_lines_held;
    assign want_cap  = (r_lines_wanted == '0 || int'(r_lines_wanted) > LINE_SLOTS)
                     ? HELD_FULL : HELD_W'(r_lines_wanted);
    assign eoi_n     = (want_cap > eoi_held) ? eoi_held : want_cap;
    assign start_sum = (HELD_W + 1)'(eoi_ws) + (HELD_W + 1)'(LINE_SLOTS)
                     - (HELD_W + 1)'(eoi_n);
    assign start_slot = (start_sum >= (HELD_W + 1)'(LINE_SLOTS))
                      ? start_sum - (HELD_W + 1)'(LINE_SLOTS) : start_sum;

    // push: a push during replay begins a fresh capture
    assign push_ws       = r_in_replay ? '0 : r_write_slot;
    assign push_ws_inc   = r_in_replay ? SLOT_W'(1) : ws_inc;
    assign push_pl       = r_in_replay ? '0 : r_partial_length;
    assign push_held_inc = r_in_replay ? HELD_W'(1) : held_inc;
    assign push_pl_new   = (OFF_W + 1)'(push_pl) + 1'b1;
    assign push_close    = (i_data_byte == NEWLINE) || (push_pl_new >= LINE_LIMIT);

    // pull: step through the current line, move to the next slot at its end
    assign pull_empty = !r_in_replay || (r_lines_remaining == '0);
    assign off_inc    = (OFF_W + 1)'(r_replay_offset) + 1'b1;
    assign pull_adv   = (off_inc >= (OFF_W + 1)'(cur_len));

    // next-state logic for one accepted beat
    always_comb begin
        n_write_slot      = r_write_slot;
        n_partial_length  = r_partial_length;
        n_lines_held      = r_lines_held;
        n_replay_slot     = r_replay_slot;
        n_replay_offset   = r_replay_offset;
        n_lines_remaining = r_lines_remaining;
        n_in_replay       = r_in_replay;
        n_s1_valid        = 1'b0;
        n_s1_has_byte     = 1'b0;
        n_s1_last         = 1'b0;
        n_s1_none         = 1'b0;
        n_s1_shown        = '0;
        store_we          = 1'b0;
        store_waddr       = {push_ws, push_pl};
        store_re          = 1'b0;
        store_raddr       = {r_replay_slot, r_replay_offset};
        len_we            = 1'b0;
        len_waddr         = r_write_slot;
        len_wdata         = r_partial_length;
        if (in_accept) begin
            case (func)
                FUNC_PUSH: begin
                    store_we = 1'b1;
                    if (r_in_replay) begin
                        n_replay_slot     = '0;
                        n_replay_offset   = '0;
                        n_lines_remaining = '0;
                        n_in_replay       = 1'b0;
                    end
                    if (push_close) begin
                        len_we           = 1'b1;
                        len_waddr        = push_ws;
                        len_wdata        = OFF_W'(push_pl_new);
                        n_write_slot     = push_ws_inc;
                        n_partial_length = '0;
                        n_lines_held     = push_held_inc;
                    end else begin
                        n_write_slot     = push_ws;
                        n_partial_length = OFF_W'(push_pl_new);
                        n_lines_held     = r_in_replay ? '0 : r_lines_held;
                    end
                end
                FUNC_EOI: begin
                    if (eoi_close) begin
                        len_we           = 1'b1;
                        n_partial_length = '0;
                    end
                    n_write_slot      = eoi_ws;
                    n_lines_held      = eoi_held;
                    n_replay_slot     = SLOT_W'(start_slot);
                    n_replay_offset   = '0;
                    n_lines_remaining = eoi_n;
                    n_in_replay       = 1'b1;
                    n_s1_valid        = 1'b1;
                    n_s1_shown        = COUNT_W'(eoi_n);
                end
                FUNC_PULL: begin
                    n_s1_valid = 1'b1;
                    if (pull_empty) begin
                        n_s1_none = 1'b1;
                    end else begin
                        store_re      = 1'b1;
                        n_s1_has_byte = 1'b1;
                        if (pull_adv) begin
                            n_replay_offset   = '0;
                            n_replay_slot     = rs_inc;
                            n_lines_remaining = rem_dec;
                            n_s1_last         = (rem_dec == '0);
                        end else begin
                            n_replay_offset   = OFF_W'(off_inc);
                        end
                    end
                end
                default: begin
                    n_s1_valid = 1'b0;
                end
            endcase
        end
    end

    // line store: one slot per line, offset in the low address bits
    lnrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_D)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_data_byte),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // slot lengths, read every cycle at the next replay slot
    lnrb_ram #(
        .WIDTH (OFF_W),
        .DEPTH (LINE_SLOTS)
    ) u_slot_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (1'b1),
        .i_raddr (n_replay_slot),
        .o_rdata (len_rdata)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_wanted <= LINES_WANTED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lines_wanted <= i_cfg_data;
        end
    end

    // pointer and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot      <= '0;
            r_partial_length  <= '0;
            r_lines_held      <= '0;
            r_replay_slot     <= '0;
            r_replay_offset   <= '0;
            r_lines_remaining <= '0;
            r_in_replay       <= 1'b0;
            r_len_hit         <= 1'b0;
        end else begin
            r_write_slot      <= n_write_slot;
            r_partial_length  <= n_partial_length;
            r_lines_held      <= n_lines_held;
            r_replay_slot     <= n_replay_slot;
            r_replay_offset   <= n_replay_offset;
            r_lines_remaining <= n_lines_remaining;
            r_in_replay       <= n_in_replay;
            r_len_hit         <= len_we && (len_waddr == n_replay_slot);
        end
    end

    // bypass data
    always_ff @(posedge i_clk) begin
        r_len_byp <= len_wdata;
    end

    // middle stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // middle stage payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_s1_has_byte <= n_s1_has_byte;
            r_s1_last     <= n_s1_last;
            r_s1_none     <= n_s1_none;
            r_s1_shown    <= n_s1_shown;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_out_byte <= r_s1_has_byte ? store_rdata : '0;
            r_o_last     <= r_s1_last;
            r_o_none     <= r_s1_none;
            r_o_shown    <= r_s1_shown;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_byte     = r_o_out_byte;
    assign o_last_byte    = r_o_last;
    assign o_nothing_left = r_o_none;
    assign o_lines_shown  = r_o_shown;

    // replay never owes more lines than are held
    a_rem_le_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lines_remaining <= r_lines_held)
        else $error("lines remaining exceed lines held");

    // outside replay nothing is owed
    a_idle_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_replay |-> (r_lines_remaining == '0))
        else $error("lines owed while capturing");

    // an open line never reaches the forced line break length
    a_partial_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OFF_W + 1)'(r_partial_length) < LINE_LIMIT)
        else $error("open line too long");

    // a final byte and an empty pull are exclusive
    a_last_vs_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_last_byte && o_nothing_left))
        else $error("last byte flagged on empty pull");

endmodule
